### src/gsu_pkg.sv
`timescale 1ns / 1ps

package gsu_pkg;

  localparam int COORD_BITS_DEF = 31;
  localparam int PITCH_W        = 16;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;
  localparam int OUT_W          = 32;

  typedef enum logic [1:0] {
    FUNC_NEAREST = 2'd0,
    FUNC_DOWN    = 2'd1,
    FUNC_UP      = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_PITCH_X  = 2'd0,
    REG_ORIGIN_X = 2'd1,
    REG_PITCH_Y  = 2'd2,
    REG_ORIGIN_Y = 2'd3
  } reg_e;

  // control that rides along with each word through the chain
  typedef struct packed {
    logic       valid;
    logic [1:0] func;
    logic       neg;
  } ctl_t;

endpackage

### src/gsu_front.sv
`timescale 1ns / 1ps

module gsu_front #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF,
  parameter int MAG_BITS   = gsu_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [1:0]                         func_i,
  input  logic                               axis_i,
  input  logic signed [COORD_BITS-1:0]       coord_i,
  input  logic [gsu_pkg::PITCH_W-1:0]        pitch_x_i,
  input  logic signed [gsu_pkg::PITCH_W-1:0] origin_x_i,
  input  logic [gsu_pkg::PITCH_W-1:0]        pitch_y_i,
  input  logic signed [gsu_pkg::PITCH_W-1:0] origin_y_i,
  output gsu_pkg::ctl_t                      ctl_o,
  output logic signed [COORD_BITS-1:0]       coord_o,
  output logic [gsu_pkg::PITCH_W-1:0]        pitch_o,
  output logic [MAG_BITS-1:0]                mag_o,
  output logic [gsu_pkg::PITCH_W-1:0]        rem_o
);
  import gsu_pkg::*;

  logic [PITCH_W-1:0]        pitch_sel;
  logic signed [PITCH_W-1:0] origin_sel;
  logic [PITCH_W-1:0]        pitch_eff;
  logic signed [MAG_BITS:0]  diff;
  logic [MAG_BITS:0]         diff_abs;

  ctl_t                      ctl_q, ctl_d;
  logic signed [COORD_BITS-1:0] coord_q;
  logic [PITCH_W-1:0]        pitch_q;
  logic [MAG_BITS-1:0]       mag_q, mag_d;

  always_comb begin
    pitch_sel  = axis_i ? pitch_y_i : pitch_x_i;
    origin_sel = axis_i ? origin_y_i : origin_x_i;
    // a zero pitch behaves as pitch one
    pitch_eff  = (pitch_sel == '0) ? PITCH_W'(1) : pitch_sel;
    diff       = (MAG_BITS+1)'(coord_i) - (MAG_BITS+1)'(origin_sel);
    diff_abs   = diff[MAG_BITS] ? (~diff + (MAG_BITS+1)'(1)) : diff;
    mag_d      = diff_abs[MAG_BITS-1:0];
    ctl_d.valid = valid_i;
    ctl_d.func  = func_i;
    ctl_d.neg   = diff[MAG_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= coord_i;
      pitch_q <= pitch_eff;
      mag_q   <= mag_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign coord_o = coord_q;
  assign pitch_o = pitch_q;
  assign mag_o   = mag_q;
  assign rem_o   = '0;

endmodule

### src/gsu_cell.sv
`timescale 1ns / 1ps

module gsu_cell #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF,
  parameter int MAG_BITS   = gsu_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  gsu_pkg::ctl_t                ctl_i,
  input  logic signed [COORD_BITS-1:0] coord_i,
  input  logic [gsu_pkg::PITCH_W-1:0]  pitch_i,
  input  logic [MAG_BITS-1:0]          mag_i,
  input  logic [gsu_pkg::PITCH_W-1:0]  rem_i,
  output gsu_pkg::ctl_t                ctl_o,
  output logic signed [COORD_BITS-1:0] coord_o,
  output logic [gsu_pkg::PITCH_W-1:0]  pitch_o,
  output logic [MAG_BITS-1:0]          mag_o,
  output logic [gsu_pkg::PITCH_W-1:0]  rem_o
);
  import gsu_pkg::*;

  logic [PITCH_W:0]   trial;
  logic [PITCH_W:0]   trial_sub;
  logic [PITCH_W-1:0] rem_d;
  logic [MAG_BITS-1:0] mag_d;

  ctl_t                         ctl_q;
  logic signed [COORD_BITS-1:0] coord_q;
  logic [PITCH_W-1:0]           pitch_q;
  logic [MAG_BITS-1:0]          mag_q;
  logic [PITCH_W-1:0]           rem_q;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_i, mag_i[MAG_BITS-1]};
    trial_sub = trial - {1'b0, pitch_i};
    rem_d     = (trial >= {1'b0, pitch_i}) ? trial_sub[PITCH_W-1:0] : trial[PITCH_W-1:0];
    mag_d     = {mag_i[MAG_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_q <= coord_i;
      pitch_q <= pitch_i;
      mag_q   <= mag_d;
      rem_q   <= rem_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign coord_o = coord_q;
  assign pitch_o = pitch_q;
  assign mag_o   = mag_q;
  assign rem_o   = rem_q;

endmodule

### src/gsu_back.sv
`timescale 1ns / 1ps

module gsu_back #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF,
  parameter int MAG_BITS   = gsu_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  gsu_pkg::ctl_t                    ctl_i,
  input  logic signed [COORD_BITS-1:0]     coord_i,
  input  logic [gsu_pkg::PITCH_W-1:0]      pitch_i,
  input  logic [gsu_pkg::PITCH_W-1:0]      rem_i,
  output logic                             valid_o,
  output logic signed [gsu_pkg::OUT_W-1:0] snapped_o
);
  import gsu_pkg::*;

  localparam int RES_W = MAG_BITS + 2;

  // fold stage
  logic [PITCH_W-1:0]           r_d;
  logic                         fold_vld_q;
  logic [1:0]                   fold_func_q;
  logic signed [COORD_BITS-1:0] fold_coord_q;
  logic [PITCH_W-1:0]           fold_pitch_q;
  logic [PITCH_W-1:0]           fold_r_q;

  // floor and rounding stage
  logic                         up_d;
  logic signed [RES_W-1:0]      lo_d;
  logic                         lo_vld_q;
  logic                         lo_up_q;
  logic signed [RES_W-1:0]      lo_q;
  logic [PITCH_W-1:0]           lo_pitch_q;

  // output stage
  logic signed [RES_W-1:0]      res;
  logic signed [OUT_W-1:0]      sat;
  logic                         out_vld_q;
  logic signed [OUT_W-1:0]      out_q;

  // remainder of a negative dividend folds to the floor remainder
  always_comb begin
    r_d = (ctl_i.neg && (rem_i != '0)) ? (pitch_i - rem_i) : rem_i;
  end

  always_comb begin
    lo_d = RES_W'(fold_coord_q) - RES_W'({1'b0, fold_r_q});
    case (func_e'(fold_func_q))
      FUNC_DOWN: up_d = 1'b0;
      FUNC_UP:   up_d = (fold_r_q != '0);
      // nearest, and the unused code; a tie stays low
      default:   up_d = ({fold_r_q, 1'b0} > {1'b0, fold_pitch_q});
    endcase
  end

  assign res = lo_q + (lo_up_q ? RES_W'({1'b0, lo_pitch_q}) : RES_W'(0));

  generate
    if (RES_W > OUT_W) begin : g_sat
      localparam logic signed [RES_W-1:0] MaxVal = RES_W'({1'b0, {(OUT_W-1){1'b1}}});
      localparam logic signed [RES_W-1:0] MinVal = -MaxVal - RES_W'(1);
      always_comb begin
        if (res > MaxVal) begin
          sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (res < MinVal) begin
          sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          sat = res[OUT_W-1:0];
        end
      end
    end else begin : g_ext
      assign sat = OUT_W'(res);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
      lo_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en_i) begin
      fold_vld_q <= ctl_i.valid;
      lo_vld_q   <= fold_vld_q;
      out_vld_q  <= lo_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_func_q  <= ctl_i.func;
      fold_coord_q <= coord_i;
      fold_pitch_q <= pitch_i;
      fold_r_q     <= r_d;
      lo_up_q      <= up_d;
      lo_q         <= lo_d;
      lo_pitch_q   <= fold_pitch_q;
      out_q        <= sat;
    end
  end

  assign valid_o   = out_vld_q;
  assign snapped_o = out_q;

endmodule

### src/grid_snap_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake               word
// input     in         in_valid_i/in_stall_o    func_i, axis_i, coord_i
// output    out        out_valid_o/out_stall_i  snapped_o
// config    in         psel/penable/pwrite      paddr, pwdata -> prdata
//
// the chain is one input stage, one divider cell per magnitude bit of (coord - origin),
// then fold, round and output stages
// a new word is taken every cycle while the output is not held
// the whole chain moves together; a held output word freezes every stage and raises in_stall_o
// reset clears the valid bits of all stages and sets pitches to 1, origins to 0

module grid_snap_unit #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       func_i,
  input  logic                             axis_i,
  input  logic signed [COORD_BITS-1:0]     coord_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gsu_pkg::OUT_W-1:0] snapped_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gsu_pkg::ADDR_W-1:0]       paddr,
  input  logic [gsu_pkg::DATA_W-1:0]       pwdata,
  output logic [gsu_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import gsu_pkg::*;

  localparam int MagBits = (COORD_BITS > PITCH_W + 1) ? COORD_BITS : PITCH_W + 1;

  logic en;

  logic [PITCH_W-1:0]        pitch_x_q, pitch_y_q;
  logic signed [PITCH_W-1:0] origin_x_q, origin_y_q;
  logic                      wr_en;
  reg_e                      reg_sel;

  ctl_t                         ctl_c   [MagBits+1];
  logic signed [COORD_BITS-1:0] coord_c [MagBits+1];
  logic [PITCH_W-1:0]           pitch_c [MagBits+1];
  logic [MagBits-1:0]           mag_c   [MagBits+1];
  logic [PITCH_W-1:0]           rem_c   [MagBits+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_x_q  <= PITCH_W'(1);
      origin_x_q <= '0;
      pitch_y_q  <= PITCH_W'(1);
      origin_y_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PITCH_X:  pitch_x_q  <= pwdata[PITCH_W-1:0];
        REG_ORIGIN_X: origin_x_q <= pwdata[PITCH_W-1:0];
        REG_PITCH_Y:  pitch_y_q  <= pwdata[PITCH_W-1:0];
        REG_ORIGIN_Y: origin_y_q <= pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PITCH_X:  prdata = DATA_W'(pitch_x_q);
      REG_ORIGIN_X: prdata = DATA_W'(origin_x_q);
      REG_PITCH_Y:  prdata = DATA_W'(pitch_y_q);
      REG_ORIGIN_Y: prdata = DATA_W'(origin_y_q);
      default:      prdata = '0;
    endcase
  end

  gsu_front #(
    .COORD_BITS (COORD_BITS),
    .MAG_BITS   (MagBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .func_i     (func_i),
    .axis_i     (axis_i),
    .coord_i    (coord_i),
    .pitch_x_i  (pitch_x_q),
    .origin_x_i (origin_x_q),
    .pitch_y_i  (pitch_y_q),
    .origin_y_i (origin_y_q),
    .ctl_o      (ctl_c[0]),
    .coord_o    (coord_c[0]),
    .pitch_o    (pitch_c[0]),
    .mag_o      (mag_c[0]),
    .rem_o      (rem_c[0])
  );

  for (genvar i = 0; i < MagBits; i++) begin : g_cell
    gsu_cell #(
      .COORD_BITS (COORD_BITS),
      .MAG_BITS   (MagBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl_c[i]),
      .coord_i (coord_c[i]),
      .pitch_i (pitch_c[i]),
      .mag_i   (mag_c[i]),
      .rem_i   (rem_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .coord_o (coord_c[i+1]),
      .pitch_o (pitch_c[i+1]),
      .mag_o   (mag_c[i+1]),
      .rem_o   (rem_c[i+1])
    );
  end

  gsu_back #(
    .COORD_BITS (COORD_BITS),
    .MAG_BITS   (MagBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (ctl_c[MagBits]),
    .coord_i   (coord_c[MagBits]),
    .pitch_i   (pitch_c[MagBits]),
    .rem_i     (rem_c[MagBits]),
    .valid_o   (out_valid_o),
    .snapped_o (snapped_o)
  );

endmodule

### src/gsu_check.sv
`timescale 1ns / 1ps

module gsu_check #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [1:0]                   func_i,
  input logic                         axis_i,
  input logic [COORD_BITS-1:0]        coord_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [gsu_pkg::OUT_W-1:0]    snapped_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [gsu_pkg::ADDR_W-1:0]   paddr,
  input logic [gsu_pkg::DATA_W-1:0]   pwdata,
  input logic [gsu_pkg::DATA_W-1:0]   prdata,
  input logic                         pready
);
  import gsu_pkg::*;

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(snapped_o)))
    else $error("output word changed while stalled");

  // a stalled input word keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(func_i) && $stable(axis_i) &&
     $stable(coord_i)))
    else $error("input word changed while stalled");

  // input is only held back by a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free output");

  // a pitch written is read back right after, zero extended
  a_pitch_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready &&
     (paddr[3:2] == REG_PITCH_X || paddr[3:2] == REG_PITCH_Y))
    ##1 (psel && !pwrite && paddr[3:2] == $past(paddr[3:2]))
    |-> (prdata == {16'h0, $past(pwdata[15:0])}))
    else $error("pitch readback mismatch");

  // origins read back sign extended
  a_origin_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !pwrite && (paddr[3:2] == REG_ORIGIN_X || paddr[3:2] == REG_ORIGIN_Y))
    |-> (prdata[31:16] == {16{prdata[15]}}))
    else $error("origin readback not sign extended");

endmodule

bind grid_snap_unit gsu_check #(.COORD_BITS(COORD_BITS)) u_gsu_check (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gsu_pkg::*;

  localparam int     CW          = COORD_BITS_DEF;
  localparam longint COORD_MAX   = 64'sd1073741823;
  localparam longint COORD_MIN   = -64'sd1073741824;
  localparam longint SNAP_MAX    = 64'sd2147483647;
  localparam longint SNAP_MIN    = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     TAIL_CYCLES = 60;
  localparam int     REPORT_MAX  = 10;
  // rounding code the package leaves unnamed, behaves as nearest
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

  // code holds the rounding mode for a word row and the register for a config row
  typedef struct {
    row_kind_e  kind;
    logic [1:0] code;
    logic       axis;
    longint     val;
    bit         has_exp;
    longint     exp;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               func_i      = '0;
  logic                     axis_i      = 1'b0;
  logic signed [CW-1:0]     coord_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]  snapped_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [ADDR_W-1:0]        paddr       = '0;
  logic [DATA_W-1:0]        pwdata      = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  grid_snap_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .axis_i      (axis_i),
    .coord_i     (coord_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .snapped_o   (snapped_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // grid settings as the block should hold them, index 0 x, 1 y
  logic [PITCH_W-1:0]        pitch_cfg  [2] = '{16'd1, 16'd1};
  logic signed [PITCH_W-1:0] origin_cfg [2] = '{16'sd0, 16'sd0};

  logic signed [OUT_W-1:0] snap_q [$];
  logic signed [OUT_W-1:0] snap_want;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int send_idle_pct = 12;
  int recv_stall_pct = 53;

  dir_row_t dir_rows [$] = '{
    // reset grid: pitch 1, origin 0, every coordinate is a grid point
    '{ROW_WORD, FUNC_NEAREST, 1'b0, 0,         1'b1, 0},
    '{ROW_WORD, FUNC_DOWN,    1'b0, COORD_MAX, 1'b1, COORD_MAX},
    '{ROW_WORD, FUNC_UP,      1'b1, COORD_MIN, 1'b1, COORD_MIN},
    '{ROW_WORD, FUNC_SPARE,   1'b1, -1,        1'b1, -1},
    '{ROW_CFG,  REG_PITCH_X,  1'b0, 10,        1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_X, 1'b0, -3,        1'b0, 0},
    '{ROW_CFG,  REG_PITCH_Y,  1'b0, 7,         1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_Y, 1'b0, 5,         1'b0, 0},
    // tie toward the lower point, then one past it
    '{ROW_WORD, FUNC_NEAREST, 1'b0, 2,         1'b0, 0},
    '{ROW_WORD, FUNC_NEAREST, 1'b0, 3,         1'b0, 0},
    // below the origin
    '{ROW_WORD, FUNC_DOWN,    1'b0, -14,       1'b0, 0},
    '{ROW_WORD, FUNC_UP,      1'b0, -14,       1'b0, 0},
    // exactly on a grid point
    '{ROW_WORD, FUNC_UP,      1'b0, 7,         1'b0, 0},
    '{ROW_WORD, FUNC_SPARE,   1'b1, 9,         1'b0, 0},
    '{ROW_WORD, FUNC_DOWN,    1'b1, COORD_MIN, 1'b0, 0},
    '{ROW_WORD, FUNC_UP,      1'b1, COORD_MAX, 1'b0, 0},
    '{ROW_CFG,  REG_PITCH_X,  1'b0, 65535,     1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_X, 1'b0, -32768,    1'b0, 0},
    // zero pitch behaves as pitch one
    '{ROW_CFG,  REG_PITCH_Y,  1'b0, 0,         1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_Y, 1'b0, 32767,     1'b0, 0},
    '{ROW_WORD, FUNC_UP,      1'b0, COORD_MAX, 1'b0, 0},
    '{ROW_WORD, FUNC_DOWN,    1'b0, COORD_MIN, 1'b0, 0},
    '{ROW_WORD, FUNC_NEAREST, 1'b0, COORD_MAX, 1'b0, 0},
    '{ROW_WORD, FUNC_NEAREST, 1'b1, COORD_MIN, 1'b0, 0},
    '{ROW_WORD, FUNC_UP,      1'b1, 12345,     1'b0, 0},
    '{ROW_CFG,  REG_PITCH_X,  1'b0, 1,         1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_X, 1'b0, 32767,     1'b0, 0},
    '{ROW_CFG,  REG_PITCH_Y,  1'b0, 2,         1'b0, 0},
    '{ROW_CFG,  REG_ORIGIN_Y, 1'b0, -1,        1'b0, 0},
    '{ROW_WORD, FUNC_NEAREST, 1'b1, 0,         1'b0, 0},
    '{ROW_WORD, FUNC_UP,      1'b1, 0,         1'b0, 0},
    '{ROW_WORD, FUNC_DOWN,    1'b0, -5,        1'b1, -5},
    '{ROW_WORD, FUNC_NEAREST, 1'b1, -2,        1'b0, 0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [OUT_W-1:0] snap_coord(input logic [1:0] f, input logic a,
                                                          input logic signed [CW-1:0] c);
    longint p, org, cv, rem, lo, res;
    p   = (pitch_cfg[a] == '0) ? 64'sd1 : longint'(pitch_cfg[a]);
    org = longint'(origin_cfg[a]);
    cv  = longint'(c);
    rem = (cv - org) % p;
    if (rem < 0) rem += p;
    lo = cv - rem;
    case (f)
      FUNC_DOWN: res = lo;
      FUNC_UP:   res = (rem != 0) ? lo + p : lo;
      default:   res = (2 * rem > p) ? lo + p : lo;
    endcase
    if (res > SNAP_MAX) res = SNAP_MAX;
    if (res < SNAP_MIN) res = SNAP_MIN;
    return res[OUT_W-1:0];
  endfunction

  function automatic logic [PITCH_W-1:0] pick_pitch();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'd1;
      3, 4:    return 16'($urandom_range(16, 2));
      5, 6:    return 16'($urandom_range(1000, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PITCH_W-1:0] pick_origin();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mix of extremes, grid points, ties and points near the origin
  function automatic logic signed [CW-1:0] pick_coord(input logic a);
    longint p, org, cv;
    p   = (pitch_cfg[a] == '0) ? 64'sd1 : longint'(pitch_cfg[a]);
    org = longint'(origin_cfg[a]);
    case ($urandom_range(9))
      0: cv = COORD_MIN;
      1: cv = COORD_MAX;
      2: cv = org + (longint'($urandom_range(2000)) - 1000) * p;
      3: cv = org + (longint'($urandom_range(2000)) - 1000) * p + p / 2
              + longint'($urandom_range(2)) - 1;
      4: cv = org + longint'($urandom_range(32'(6 * p))) - 3 * p;
      default: cv = longint'($signed(CW'($urandom)));
    endcase
    if (cv > COORD_MAX) cv = COORD_MAX;
    if (cv < COORD_MIN) cv = COORD_MIN;
    return cv[CW-1:0];
  endfunction

  task automatic push_word(input logic [1:0] f, input logic a, input logic signed [CW-1:0] c,
                           input logic signed [OUT_W-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    axis_i     <= a;
    coord_i    <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    snap_q.push_back(want);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (snap_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [PITCH_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PITCH_X:  pitch_cfg[0]  = val;
      REG_ORIGIN_X: origin_cfg[0] = val;
      REG_PITCH_Y:  pitch_cfg[1]  = val;
      REG_ORIGIN_Y: origin_cfg[1] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : stim
    logic [1:0]          f;
    logic                a;
    logic signed [CW-1:0] c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(reg_e'(dir_rows[i].code), dir_rows[i].val[PITCH_W-1:0]);
      end else begin
        f = dir_rows[i].code;
        a = dir_rows[i].axis;
        c = dir_rows[i].val[CW-1:0];
        push_word(f, a, c, dir_rows[i].has_exp ? dir_rows[i].exp[OUT_W-1:0]
                                              : snap_coord(f, a, c));
      end
    end

    for (int seg = 0; seg < 12; seg++) begin
      send_idle_pct  = (seg < 4) ? 12 : (seg < 8) ? 53 : 0;
      recv_stall_pct = (seg < 4) ? 53 : (seg < 8) ? 12 : 0;
      wait_drained();
      write_reg(REG_PITCH_X,  pick_pitch());
      write_reg(REG_ORIGIN_X, pick_origin());
      write_reg(REG_PITCH_Y,  pick_pitch());
      write_reg(REG_ORIGIN_Y, pick_origin());
      repeat (120) begin
        f = 2'($urandom_range(3));
        a = 1'($urandom_range(1));
        c = pick_coord(a);
        push_word(f, a, c, snap_coord(f, a, c));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** grid_snap_unit: PASSED **");
    end else begin
      $display("** grid_snap_unit: FAILED **");
    end
    $finish;
  end

  // result side: check each word taken, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (snap_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) $display("unexpected word: snapped %0d", snapped_o);
      end else begin
        snap_want = snap_q.pop_front();
        if (snapped_o !== snap_want) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("snapped mismatch: expected %0d, got %0d", snap_want, snapped_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", snap_q.size());
      $display("** grid_snap_unit: FAILED **");
      $finish;
    end
  end

endmodule
